[rtl/greedy_neighbor_partition_assign_top_assert.svh]
// Assertion macros for the greedy partition assignment block.
// Used by greedy_neighbor_partition_assign_top; expects clk and arst_n in scope.
`ifndef GREEDY_NEIGHBOR_PARTITION_ASSIGN_TOP_ASSERT_SVH
`define GREEDY_NEIGHBOR_PARTITION_ASSIGN_TOP_ASSERT_SVH

// Implication checked at the same clock edge.
`define GNPA_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Implication checked at the next clock edge.
`define GNPA_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[rtl/gnpa_pkg.sv]
// Package for the greedy partition assignment block.
// Holds default sizes, command and register codes and the controller state type.
`timescale 1ns / 1ps
`default_nettype none
package gnpa_pkg;
	localparam int MAX_VERTICES_DEF = 1048576;
	localparam int MAX_PARTS_DEF    = 256;
	localparam int DEGREE_BITS_DEF  = 22;

	localparam logic [1:0] CMD_START    = 2'd0;
	localparam logic [1:0] CMD_HEADER   = 2'd1;
	localparam logic [1:0] CMD_NEIGHBOR = 2'd2;

	localparam logic CFG_NUM_PARTS = 1'b0;
	localparam logic CFG_CAPACITY  = 1'b1;

	localparam logic [8:0]  NUM_PARTS_RST = 9'd2;
	localparam logic [31:0] CAPACITY_RST  = 32'd33554432;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NB_RD,
		ST_HIT_RD,
		ST_SCAN1,
		ST_SCAN2,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_FAIL
	} gnpa_state_t;
endpackage
`default_nettype wire

[rtl/greedy_neighbor_partition_assign_top.sv]
// Greedy streaming partition assignment, top level.
// Depends on gnpa_pkg and greedy_neighbor_partition_assign_top_assert.svh.
//
// Usage. Items arrive on the item channel (item_valid, item_stall, command, vertex,
// degree) and are taken at an edge where item_valid is high and item_stall low.
// A start-pass item launches a clearing sweep over max(MAX_VERTICES, MAX_PARTS)
// addresses of the vertex table and the partition size and member tables; the same
// sweep runs after reset. Item_stall is high during the sweep.
// A neighbor item is handled as a read of the vertex table, then, for a neighbor
// that has a partition, a read-modify-write of the hit counter memory.
// After the last neighbor (or a header of degree 0) the decision scans the hit
// and size memories once, one partition per cycle, plus a second scan when the
// best hit count is zero.
// Results leave through an output register on the result channel (result_valid,
// result_stall). While a result waits, the block goes on accepting items and
// only holds when the next result is ready. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_neighbor_partition_assign_top_assert.svh"
module greedy_neighbor_partition_assign_top
	import gnpa_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_PARTS    = MAX_PARTS_DEF,
	parameter int DEGREE_BITS  = DEGREE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  command,
	input  wire logic [19:0] vertex,
	input  wire logic [21:0] degree,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [19:0]      vertex_id,
	output logic [7:0]       assigned_part,
	output logic [21:0]      best_hits,
	output logic [31:0]      part_size_after,
	output logic             failed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int VADDR_W = $clog2(MAX_VERTICES);
	localparam int PART_W  = $clog2(MAX_PARTS);
	localparam int PCNT_W  = PART_W + 1;
	localparam int VP_W    = PART_W + 1;
	localparam int NEED_W  = DEGREE_BITS + 1;
	localparam int CLR_N   = (MAX_VERTICES > MAX_PARTS) ? MAX_VERTICES : MAX_PARTS;
	localparam int CLR_W   = $clog2(CLR_N + 1);
	localparam logic [DEGREE_BITS-1:0] HIT_MAX = '1;

	gnpa_state_t state_q, state_d;

	logic [8:0]  num_parts_q;
	logic [31:0] capacity_q;

	logic [VP_W-1:0]        vp_mem [MAX_VERTICES];
	logic [DEGREE_BITS-1:0] hit_mem [MAX_PARTS];
	logic [31:0]            ps_mem [MAX_PARTS];
	logic [19:0]            pvc_mem [MAX_PARTS];

	logic [VP_W-1:0]        vp_rd_q;
	logic [DEGREE_BITS-1:0] hit_rd_q;
	logic [31:0]            ps_rd_q;
	logic [19:0]            pvc_rd_q;

	logic [VADDR_W-1:0]     vp_raddr, vp_waddr;
	logic [VP_W-1:0]        vp_wdata;
	logic                   vp_we;
	logic [PART_W-1:0]      hit_raddr, ps_raddr, ps_waddr;
	logic [DEGREE_BITS-1:0] hit_wdata;
	logic                   hit_we;
	logic [31:0]            ps_wdata;
	logic [19:0]            pvc_wdata;
	logic                   ps_we;

	logic [CLR_W-1:0]       clr_q;
	logic [19:0]            cur_q;
	logic [DEGREE_BITS-1:0] rem_q;
	logic [NEED_W-1:0]      need_q;
	logic [MAX_PARTS-1:0]   hv_q;
	logic                   nb_in_q;
	logic [PART_W-1:0]      p_q;
	logic [PCNT_W-1:0]      idx_q;
	logic                   vld_s1;
	logic [PART_W-1:0]      idx_s1;
	logic                   found_q;
	logic [DEGREE_BITS-1:0] best_q;
	logic [PART_W-1:0]      pick_q;
	logic [31:0]            smallest_q;

	logic                   result_valid_q;
	logic [19:0]            vertex_id_q;
	logic [7:0]             assigned_part_q;
	logic [21:0]            best_hits_q;
	logic [31:0]            part_size_after_q;
	logic                   failed_q;

	logic                   item_acc, out_free, scan_issue, scan_done, fits, cur_in;
	logic [31:0]            np32, v32, d32, cur32;
	logic [PCNT_W-1:0]      np_w;
	logic [DEGREE_BITS-1:0] deg_in, hit_val, hit_cur;
	logic [VP_W-1:0]        vp_minus;
	logic [31:0]            new_size;
	logic [31:0]            pick32;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (num_parts_q == 9'd0) begin
			np32 = 32'd1;
		end else if (32'(num_parts_q) > 32'(MAX_PARTS)) begin
			np32 = 32'(MAX_PARTS);
		end else begin
			np32 = 32'(num_parts_q);
		end
	end
	assign np_w = np32[PCNT_W-1:0];

	assign v32      = 32'(vertex);
	assign d32      = 32'(degree);
	assign cur32    = 32'(cur_q);
	assign deg_in   = d32[DEGREE_BITS-1:0];
	assign vp_raddr = v32[VADDR_W-1:0];
	assign cur_in   = cur32 < 32'(MAX_VERTICES);
	assign vp_minus = vp_rd_q - VP_W'(1);
	assign hit_val  = hv_q[idx_s1] ? hit_rd_q : '0;
	assign hit_cur  = hv_q[p_q] ? hit_rd_q : '0;
	assign fits     = ({1'b0, ps_rd_q} + 33'(need_q)) <= {1'b0, capacity_q};
	assign new_size = ps_rd_q + 32'(need_q);
	assign pick32   = 32'(pick_q);

	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign scan_issue = idx_q < np_w;
	assign scan_done  = !scan_issue && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		hit_raddr  = idx_q[PART_W-1:0];
		ps_raddr   = pick_q;
		vp_we      = 1'b0;
		vp_waddr   = clr_q[VADDR_W-1:0];
		vp_wdata   = '0;
		ps_we      = 1'b0;
		ps_waddr   = clr_q[PART_W-1:0];
		ps_wdata   = '0;
		pvc_wdata  = '0;
		hit_we     = 1'b0;
		hit_wdata  = hit_cur + DEGREE_BITS'(1);
		unique case (state_q)
			ST_CLEAR: begin
				vp_we = 32'(clr_q) < 32'(MAX_VERTICES);
				ps_we = 32'(clr_q) < 32'(MAX_PARTS);
				if (32'(clr_q) == 32'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					priority if (command == CMD_START) begin
						state_d = ST_CLEAR;
					end else if (command == CMD_HEADER) begin
						state_d = (deg_in == '0) ? ST_SCAN1 : ST_IDLE;
					end else if (command == CMD_NEIGHBOR && rem_q != '0) begin
						state_d = ST_NB_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NB_RD: begin
				hit_raddr = vp_minus[PART_W-1:0];
				if (nb_in_q && vp_rd_q != '0) begin
					state_d = ST_HIT_RD;
				end else begin
					state_d = (rem_q == '0) ? ST_SCAN1 : ST_IDLE;
				end
			end
			ST_HIT_RD: begin
				hit_raddr = p_q;
				hit_we    = hit_cur != HIT_MAX;
				state_d   = (rem_q == '0) ? ST_SCAN1 : ST_IDLE;
			end
			ST_SCAN1: begin
				ps_raddr = idx_q[PART_W-1:0];
				if (scan_done) begin
					if (!found_q) begin
						state_d = ST_FAIL;
					end else if (best_q == '0) begin
						state_d = ST_SCAN2;
					end else begin
						state_d = ST_UPD_RD;
					end
				end
			end
			ST_SCAN2: begin
				ps_raddr = idx_q[PART_W-1:0];
				if (scan_done) begin
					state_d = ST_UPD_RD;
				end
			end
			ST_UPD_RD: begin
				state_d = ST_UPD_WR;
			end
			ST_UPD_WR: begin
				if (out_free) begin
					vp_we     = cur_in;
					vp_waddr  = cur32[VADDR_W-1:0];
					vp_wdata  = VP_W'(pick_q) + VP_W'(1);
					ps_we     = 1'b1;
					ps_waddr  = pick_q;
					ps_wdata  = new_size;
					pvc_wdata = pvc_rd_q + 20'd1;
					state_d   = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vp_we) begin
			vp_mem[vp_waddr] <= vp_wdata;
		end
		vp_rd_q <= vp_mem[vp_raddr];
	end

	always_ff @(posedge clk) begin
		if (hit_we) begin
			hit_mem[p_q] <= hit_wdata;
		end
		hit_rd_q <= hit_mem[hit_raddr];
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[ps_waddr]  <= ps_wdata;
			pvc_mem[ps_waddr] <= pvc_wdata;
		end
		ps_rd_q  <= ps_mem[ps_raddr];
		pvc_rd_q <= pvc_mem[pick_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_parts_q <= NUM_PARTS_RST;
			capacity_q  <= CAPACITY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NUM_PARTS: num_parts_q <= cfg_data[8:0];
				CFG_CAPACITY:  capacity_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			cur_q      <= '0;
			rem_q      <= '0;
			need_q     <= NEED_W'(2);
			hv_q       <= '0;
			nb_in_q    <= 1'b0;
			p_q        <= '0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			pick_q     <= '0;
			smallest_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (item_acc && command == CMD_START) begin
				clr_q  <= '0;
				cur_q  <= '0;
				rem_q  <= '0;
				need_q <= NEED_W'(2);
				hv_q   <= '0;
			end
			if (item_acc && command == CMD_HEADER) begin
				cur_q  <= vertex;
				rem_q  <= deg_in;
				need_q <= {1'b0, deg_in} + NEED_W'(2);
				hv_q   <= '0;
			end
			if (item_acc && command == CMD_NEIGHBOR && rem_q != '0) begin
				rem_q   <= rem_q - DEGREE_BITS'(1);
				nb_in_q <= v32 < 32'(MAX_VERTICES);
			end
			if (state_q == ST_NB_RD) begin
				p_q <= vp_minus[PART_W-1:0];
			end
			if (state_q == ST_HIT_RD && hit_we) begin
				hv_q[p_q] <= 1'b1;
			end
			if (state_q == ST_SCAN1 && vld_s1) begin
				if ((!found_q || hit_val > best_q) && fits) begin
					found_q <= 1'b1;
					best_q  <= hit_val;
					pick_q  <= idx_s1;
				end
			end
			if (state_q == ST_SCAN2 && vld_s1) begin
				if (idx_s1 == '0) begin
					smallest_q <= ps_rd_q;
				end else if (ps_rd_q < smallest_q && fits) begin
					pick_q     <= idx_s1;
					smallest_q <= ps_rd_q;
				end
			end
			if (state_d == ST_SCAN1 && state_q != ST_SCAN1) begin
				idx_q   <= '0;
				vld_s1  <= 1'b0;
				found_q <= 1'b0;
			end else if (state_d == ST_SCAN2 && state_q != ST_SCAN2) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
			end else if (state_q == ST_SCAN1 || state_q == ST_SCAN2) begin
				idx_q  <= idx_q + PCNT_W'(scan_issue);
				vld_s1 <= scan_issue;
				idx_s1 <= idx_q[PART_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free && (state_q == ST_UPD_WR || state_q == ST_FAIL)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_UPD_WR) begin
			vertex_id_q       <= cur_q;
			assigned_part_q   <= pick32[7:0];
			best_hits_q       <= 22'(best_q);
			part_size_after_q <= new_size;
			failed_q          <= 1'b0;
		end else if (out_free && state_q == ST_FAIL) begin
			vertex_id_q       <= cur_q;
			assigned_part_q   <= '0;
			best_hits_q       <= '0;
			part_size_after_q <= '0;
			failed_q          <= 1'b1;
		end
	end

	assign result_valid    = result_valid_q;
	assign vertex_id       = vertex_id_q;
	assign assigned_part   = assigned_part_q;
	assign best_hits       = best_hits_q;
	assign part_size_after = part_size_after_q;
	assign failed          = failed_q;

	`GNPA_ASSERT_NOW(a_result_source, $rose(result_valid_q),
		$past(state_q) == ST_UPD_WR || $past(state_q) == ST_FAIL,
		"result raised outside a decision")
	`GNPA_ASSERT_NOW(a_fail_zero, result_valid_q && failed_q,
		assigned_part_q == '0 && best_hits_q == '0 && part_size_after_q == '0,
		"failure result carries non-zero fields")
	`GNPA_ASSERT_NOW(a_scan_closed, state_q == ST_SCAN1 && $past(state_q) != ST_SCAN1,
		rem_q == '0, "decision started with neighbors outstanding")
	`GNPA_ASSERT_NEXT(a_clear_hold, state_q == ST_CLEAR && state_d == ST_CLEAR,
		item_stall, "item taken during clearing sweep")
endmodule
`default_nettype wire

[tb/sv/tb_greedy_neighbor_partition_assign_top.sv]
// Testbench for the greedy streaming partition assignment block.
// Predicts every partition decision from the stimulus and checks each result item.
// Depends on gnpa_pkg and greedy_neighbor_partition_assign_top.
`timescale 1ns / 1ps
module tb_greedy_neighbor_partition_assign_top;
	import gnpa_pkg::*;

	localparam int  PARTS      = 256;
	localparam int  SETTLE     = 700;
	localparam longint LIMIT   = 12000000;

	typedef struct packed {
		logic [19:0] vid;
		logic [7:0]  part;
		logic [21:0] hits;
		logic [31:0] size;
		logic        fail;
	} decision_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  command = CMD_START;
	logic [19:0] vertex = '0;
	logic [21:0] degree = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [19:0] vertex_id;
	logic [7:0]  assigned_part;
	logic [21:0] best_hits;
	logic [31:0] part_size_after;
	logic        failed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_NUM_PARTS;
	logic [31:0] cfg_data = '0;

	greedy_neighbor_partition_assign_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .vertex(vertex), .degree(degree),
		.result_valid(result_valid), .result_stall(result_stall),
		.vertex_id(vertex_id), .assigned_part(assigned_part), .best_hits(best_hits),
		.part_size_after(part_size_after), .failed(failed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor state.
	int          vertex_owner [int];
	logic [21:0] hit_count [PARTS];
	logic [31:0] part_words [PARTS];
	logic [19:0] part_members [PARTS];
	logic [19:0] open_vertex;
	logic [21:0] open_degree;
	logic [21:0] left_neighbors;
	logic [8:0]  parts_reg = NUM_PARTS_RST;
	logic [31:0] capacity_reg = CAPACITY_RST;

	decision_t   pending_decisions [$];
	int          errors = 0;
	longint      cycles = 0;
	bit          sender_gaps = 1'b0;
	bit          receiver_gaps = 1'b0;
	int          hold_off = 0;
	int          stall_left = 0;
	bit          stall_now = 1'b0;
	int          recent [$];

	function automatic bit fits(int p, longint need);
		return longint'(part_words[p]) + need <= longint'(capacity_reg);
	endfunction

	function automatic void clear_tables();
		vertex_owner.delete();
		for (int i = 0; i < PARTS; i++) begin
			hit_count[i] = '0;
			part_words[i] = '0;
			part_members[i] = '0;
		end
		open_vertex = '0;
		open_degree = '0;
		left_neighbors = '0;
	endfunction

	function automatic void choose_partition();
		int np;
		longint need;
		longint best;
		int pick;
		logic [31:0] smallest;
		decision_t d;
		np = (parts_reg == 0) ? 1 : ((parts_reg > PARTS) ? PARTS : int'(parts_reg));
		need = longint'(open_degree) + 2;
		best = -1;
		pick = 0;
		for (int i = 0; i < np; i++)
			if (longint'(hit_count[i]) > best && fits(i, need)) begin
				best = longint'(hit_count[i]);
				pick = i;
			end
		d = '0;
		d.vid = open_vertex;
		if (best < 0) begin
			d.fail = 1'b1;
		end else begin
			if (best == 0) begin
				smallest = part_words[0];
				for (int i = 0; i < np; i++)
					if (part_words[i] < smallest && fits(i, need)) begin
						pick = i;
						smallest = part_words[i];
					end
			end
			part_words[pick] = part_words[pick] + 32'(need);
			part_members[pick] = part_members[pick] + 20'd1;
			vertex_owner[int'(open_vertex)] = pick;
			d.part = pick[7:0];
			d.hits = best[21:0];
			d.size = part_words[pick];
		end
		pending_decisions.insert(pending_decisions.size(), d);
	endfunction

	function automatic void predict_item(logic [1:0] cmd, logic [19:0] v, logic [21:0] deg);
		int p;
		if (cmd == CMD_START) begin
			clear_tables();
		end else if (cmd == CMD_HEADER) begin
			open_vertex = v;
			open_degree = deg;
			left_neighbors = deg;
			for (int i = 0; i < PARTS; i++) hit_count[i] = '0;
			if (deg == 0) choose_partition();
		end else if (cmd == CMD_NEIGHBOR && left_neighbors != 0) begin
			if (vertex_owner.exists(int'(v))) begin
				p = vertex_owner[int'(v)];
				if (hit_count[p] != '1) hit_count[p] = hit_count[p] + 22'd1;
			end
			left_neighbors = left_neighbors - 22'd1;
			if (left_neighbors == 0) choose_partition();
		end
	endfunction

	initial clear_tables();

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && item_valid && !item_stall) predict_item(command, vertex, degree);

	always @(posedge clk) begin
		decision_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_decisions.size() == 0) begin
				$display("%0t: unexpected result item vertex_id %0d", $time, vertex_id);
				errors++;
			end else begin
				e = pending_decisions.pop_front();
				if (vertex_id !== e.vid) begin
					$display("%0t: vertex_id exp %0d got %0d", $time, e.vid, vertex_id);
					errors++;
				end
				if (assigned_part !== e.part) begin
					$display("%0t: assigned_part exp %0d got %0d", $time, e.part, assigned_part);
					errors++;
				end
				if (best_hits !== e.hits) begin
					$display("%0t: best_hits exp %0d got %0d", $time, e.hits, best_hits);
					errors++;
				end
				if (part_size_after !== e.size) begin
					$display("%0t: part_size_after exp %0d got %0d", $time, e.size,
						part_size_after);
					errors++;
				end
				if (failed !== e.fail) begin
					$display("%0t: failed exp %0d got %0d", $time, e.fail, failed);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result_stall <= 1'b1;
		end else if (!receiver_gaps) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= stall_now;
		end else begin
			stall_now <= $urandom_range(0, 1);
			stall_left <= $urandom_range(1, 17);
			result_stall <= 1'b0;
		end
	end

	task automatic send_item(logic [1:0] cmd, logic [19:0] v, logic [21:0] deg);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		vertex <= v;
		degree <= deg;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_NUM_PARTS) parts_reg = value[8:0];
		else capacity_reg = value;
	endtask

	task automatic configure(logic [8:0] np, logic [31:0] cap);
		write_reg(CFG_NUM_PARTS, {23'($urandom_range(0, 32'h7FFFFF)), np});
		write_reg(CFG_CAPACITY, cap);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [19:0] pick_vertex();
		if (recent.size() != 0 && $urandom_range(0, 3) != 0)
			return 20'(recent[$urandom_range(0, recent.size() - 1)]);
		return 20'($urandom_range(0, 32'hFFFFF));
	endfunction

	task automatic send_list(logic [19:0] v, int deg, int cut);
		send_item(CMD_HEADER, v, 22'(deg));
		for (int i = 0; i < deg && i < cut; i++) send_item(CMD_NEIGHBOR, pick_vertex(), 22'($urandom));
		recent.insert(recent.size(), int'(v));
		if (recent.size() > 48) void'(recent.pop_front());
	endtask

	task automatic test_directed();
		configure(9'd4, 32'd40);
		send_list(20'd0, 0, 0);
		send_list(20'hFFFFF, 0, 0);
		send_list(20'd5, 3, 3);
		send_item(CMD_HEADER, 20'd6, 22'd2);
		send_item(CMD_NEIGHBOR, 20'd0, 22'h3FFFFF);
		send_item(CMD_NEIGHBOR, 20'hFFFFF, 22'd0);
		send_item(CMD_HEADER, 20'd7, 22'h3FFFFF);
		send_item(CMD_HEADER, 20'd8, 22'd1);
		send_item(2'd3, 20'd8, 22'd1);
		send_item(CMD_NEIGHBOR, 20'd6, 22'd0);
		send_item(CMD_NEIGHBOR, 20'd6, 22'd0);
		send_list(20'd9, 30, 30);
		send_list(20'd10, 36, 36);
		wait_idle();
		configure(9'd0, 32'd1);
		send_list(20'd11, 0, 0);
		send_item(CMD_START, 20'd0, 22'd0);
		wait_idle();
		configure(9'h1FF, 32'hFFFFFFFF);
		send_list(20'd12, 0, 0);
		send_list(20'd13, 2, 2);
		send_list(20'd12, 1, 1);
		wait_idle();
	endtask

	task automatic random_phase(int n_items);
		int sent;
		int deg;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0: begin
					send_item(2'd3, 20'($urandom), 22'($urandom));
					sent++;
				end
				1: begin
					send_item(CMD_NEIGHBOR, 20'($urandom), 22'($urandom));
					sent++;
				end
				2: begin
					deg = $urandom_range(1, 10);
					send_list(pick_vertex(), deg, $urandom_range(0, deg - 1));
					sent += deg;
				end
				3: begin
					send_item(CMD_HEADER, 20'($urandom), 22'($urandom));
					sent++;
				end
				default: begin
					deg = $urandom_range(0, 12);
					send_list(pick_vertex(), deg, deg);
					sent += deg + 1;
				end
			endcase
		end
	endtask

	task automatic test_random();
		logic [8:0] np;
		for (int ph = 0; ph < 14; ph++) begin
			np = 9'($urandom_range(1, 12));
			if (ph == 5) np = 9'd1;
			if (ph == 9) np = 9'd256;
			configure(np, (ph % 4 == 3) ? 32'hFFFFFFFF : 32'($urandom_range(20, 3000)));
			random_phase((ph == 9) ? 30 : 110);
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		configure(9'd3, 32'hFFFFFFFF);
		@(posedge clk);
		hold_off <= 3000;
		for (int i = 0; i < 40; i++) send_list(20'($urandom), 0, 0);
		random_phase(60);
		item_valid <= 1'b0;
		while (pending_decisions.size() != 0) @(posedge clk);
		random_phase(60);
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		configure(9'd6, 32'd2000);
		random_phase(120);
		wait_idle();
		if (errors == 0 && pending_decisions.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
